/* rtl/rau_pkg.sv */
// shared constants, codes and item type of the rational arithmetic unit
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int PW = 2 * WIDTH;
  localparam int CW = $clog2(PW + 1);
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_CMP = 3'd4;
  localparam logic [2:0] MODE_TRUNC = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // classified item passed from front to back
  typedef struct packed {
    logic             early;
    logic [2:0]       mode;
    logic [1:0]       status;
    logic             an;
    logic             bn;
    logic [WIDTH-1:0] anm;
    logic [WIDTH-1:0] adm;
    logic [WIDTH-1:0] bnm;
    logic [WIDTH-1:0] bdm;
  } rau_item_t;

endpackage

/* rtl/rau_if.sv */
// item channels of the rational arithmetic unit
interface rau_in_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       mode;
  logic signed [rau_pkg::WIDTH-1:0] a_num;
  logic signed [rau_pkg::WIDTH-1:0] a_den;
  logic signed [rau_pkg::WIDTH-1:0] b_num;
  logic signed [rau_pkg::WIDTH-1:0] b_den;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::WIDTH-1:0] res_num;
  logic [rau_pkg::WIDTH-2:0]        res_den;
  logic                             is_less;
  logic                             is_equal;
  logic [1:0]                       status;
  modport source (output valid, res_num, res_den, is_less, is_equal, status, input ready);
  modport sink (input valid, res_num, res_den, is_less, is_equal, status, output ready);
endinterface

/* rtl/rau_front.sv */
// front end: accepts items, splits signs and magnitudes, flags early results
module rau_front (
  rau_in_if.sink              in_ch,
  input  logic                full,
  output logic                push,
  output rau_pkg::rau_item_t  item
);

  logic [rau_pkg::WIDTH-1:0] anm, adm, bnm, bdm;
  logic                      san, sad, sbn, sbd, bn_raw;

  assign san = in_ch.a_num[rau_pkg::WIDTH-1];
  assign sad = in_ch.a_den[rau_pkg::WIDTH-1];
  assign sbn = in_ch.b_num[rau_pkg::WIDTH-1];
  assign sbd = in_ch.b_den[rau_pkg::WIDTH-1];
  assign anm = san ? -in_ch.a_num : in_ch.a_num;
  assign adm = sad ? -in_ch.a_den : in_ch.a_den;
  assign bnm = sbn ? -in_ch.b_num : in_ch.b_num;
  assign bdm = sbd ? -in_ch.b_den : in_ch.b_den;
  assign bn_raw = (sbn != sbd) && (bnm != '0);

  assign in_ch.ready = !full;
  assign push = in_ch.valid && !full;

  always_comb begin
    item.mode = in_ch.mode;
    item.anm = anm;
    item.adm = adm;
    item.bnm = bnm;
    item.bdm = bdm;
    item.an = (san != sad) && (anm != '0);
    item.bn = (in_ch.mode == rau_pkg::MODE_SUB) ? (!bn_raw && bnm != '0) : bn_raw;
    item.early = 1'b0;
    item.status = rau_pkg::ST_OK;
    if (in_ch.mode > rau_pkg::MODE_TRUNC) begin
      item.early = 1'b1;
    end else if (adm == '0 || (in_ch.mode != rau_pkg::MODE_TRUNC && bdm == '0)) begin
      item.early = 1'b1;
      item.status = rau_pkg::ST_ZERO_DEN;
    end else if (in_ch.mode == rau_pkg::MODE_DIV && bnm == '0) begin
      item.early = 1'b1;
      item.status = rau_pkg::ST_DIV_ZERO;
    end
  end

endmodule

/* rtl/rau_queue.sv */
// short item queue between front and back
module rau_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rau_pkg::rau_item_t wr_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output rau_pkg::rau_item_t rd_item
);

  rau_pkg::rau_item_t            slots [rau_pkg::QDEPTH];
  logic [rau_pkg::QAW-1:0]       wptr, rptr;
  logic [rau_pkg::QAW:0]         count;

  assign full = (count == (rau_pkg::QAW+1)'(rau_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/rau_back.sv */
// back end: products, gcd reduction, quotient division and result register
module rau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rau_pkg::rau_item_t q_item,
  output logic               pop,
  rau_out_if.source          out_ch
);

  localparam int W = rau_pkg::WIDTH;
  localparam int PW = rau_pkg::PW;
  localparam int CW = rau_pkg::CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  logic [2:0]    st;
  logic [1:0]    mstep;
  logic [CW-1:0] cnt;
  logic [2:0]    mode;
  logic          an, bn, rn;
  logic [W-1:0]  anm, adm, bnm, bdm;
  logic [PW-1:0] p1, p2, n, d, u, v, rem_n, rem_d;

  logic signed [W-1:0] pend_num;
  logic [W-2:0]        pend_den;
  logic                pend_lt, pend_eq;
  logic [1:0]          pend_st;

  logic                ov;
  logic signed [W-1:0] o_num;
  logic [W-2:0]        o_den;
  logic                o_lt, o_eq;
  logic [1:0]          o_st;

  logic [W-1:0]  mx, my;
  logic [PW-1:0] prod;
  logic          addsub;
  logic [PW-1:0] nval, dval;
  logic          rval;
  logic [PW:0]   tn, td;
  logic          rnz, ovf;

  assign pop = (st == S_IDLE) && q_valid;
  assign addsub = (mode == rau_pkg::MODE_ADD) || (mode == rau_pkg::MODE_SUB);

  assign out_ch.valid = ov;
  assign out_ch.res_num = o_num;
  assign out_ch.res_den = o_den;
  assign out_ch.is_less = o_lt;
  assign out_ch.is_equal = o_eq;
  assign out_ch.status = o_st;

  // shared multiplier operands
  always_comb begin
    mx = (mstep == 2'd0) ? anm : adm;
    case (mstep)
      2'd0:    my = (mode == rau_pkg::MODE_MUL) ? bnm : bdm;
      2'd1:    my = (mode == rau_pkg::MODE_MUL) ? bdm : bnm;
      default: my = bdm;
    endcase
    prod = PW'(mx) * PW'(my);
  end

  // signed combine of cross products for add/sub; other modes pass the products on as numerator and denominator
  always_comb begin
    if (addsub) begin
      dval = d;
      if (an == bn) begin
        nval = p1 + p2;
        rval = an;
      end else if (p1 >= p2) begin
        nval = p1 - p2;
        rval = an;
      end else begin
        nval = p2 - p1;
        rval = bn;
      end
    end else begin
      nval = p1;
      dval = p2;
      rval = an ^ bn;
    end
  end

  assign tn = {rem_n, n[PW-1]} - {1'b0, u};
  assign td = {rem_d, d[PW-1]} - {1'b0, u};

  assign rnz = rn && (n != '0);
  assign ovf = (n > (rnz ? LIM : LIM - 1'b1)) ||
               (mode != rau_pkg::MODE_TRUNC && d > LIM - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ov <= 1'b0;
    end else begin
      // a taken result frees the output register unless a new one is loaded below
      if (out_ch.valid && out_ch.ready && st != S_OUT) begin
        ov <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (q_valid) begin
            mode <= q_item.mode;
            an <= q_item.an;
            bn <= q_item.bn;
            anm <= q_item.anm;
            adm <= q_item.adm;
            bnm <= q_item.bnm;
            bdm <= q_item.bdm;
            mstep <= 2'd0;
            if (q_item.early) begin
              pend_num <= '0;
              pend_den <= (W-1)'(1);
              pend_lt <= 1'b0;
              pend_eq <= 1'b0;
              pend_st <= q_item.status;
              st <= S_OUT;
            end else if (q_item.mode == rau_pkg::MODE_TRUNC) begin
              n <= PW'(q_item.anm);
              d <= '0;
              u <= PW'(q_item.adm);
              rn <= q_item.an;
              rem_n <= '0;
              rem_d <= '0;
              cnt <= CW'(PW);
              st <= S_DIV;
            end else begin
              st <= S_MUL;
            end
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: p1 <= prod;
            2'd1: p2 <= prod;
            default: d <= prod;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd2 || (mstep == 2'd1 && !addsub)) begin
            st <= S_COMB;
          end
        end
        S_COMB: begin
          if (mode == rau_pkg::MODE_CMP) begin
            pend_num <= '0;
            pend_den <= (W-1)'(1);
            pend_st <= rau_pkg::ST_OK;
            if (an != bn) begin
              pend_lt <= an;
              pend_eq <= 1'b0;
            end else begin
              pend_eq <= (p1 == p2);
              pend_lt <= an ? (p1 > p2) : (p1 < p2);
            end
            st <= S_OUT;
          end else if (nval == '0) begin
            pend_num <= '0;
            pend_den <= (W-1)'(1);
            pend_lt <= 1'b0;
            pend_eq <= 1'b0;
            pend_st <= rau_pkg::ST_OK;
            st <= S_OUT;
          end else begin
            n <= nval;
            d <= dval;
            u <= nval;
            v <= dval;
            rn <= rval;
            st <= S_GCD;
          end
        end
        S_GCD: begin
          // one binary gcd step; common factors of two leave n and d too
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            n <= n >> 1;
            d <= d >> 1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (v == '0) begin
            rem_n <= '0;
            rem_d <= '0;
            cnt <= CW'(PW);
            st <= S_DIV;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= v;
            v <= u - v;
          end else begin
            v <= v - u;
          end
        end
        S_DIV: begin
          // restoring division of n and d by u, one bit each cycle
          if (!tn[PW]) begin
            rem_n <= tn[PW-1:0];
            n <= {n[PW-2:0], 1'b1};
          end else begin
            rem_n <= {rem_n[PW-2:0], n[PW-1]};
            n <= {n[PW-2:0], 1'b0};
          end
          if (!td[PW]) begin
            rem_d <= td[PW-1:0];
            d <= {d[PW-2:0], 1'b1};
          end else begin
            rem_d <= {rem_d[PW-2:0], d[PW-1]};
            d <= {d[PW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          pend_lt <= 1'b0;
          pend_eq <= 1'b0;
          if (ovf) begin
            pend_num <= '0;
            pend_den <= (W-1)'(1);
            pend_st <= rau_pkg::ST_OVERFLOW;
          end else begin
            pend_num <= rnz ? -n[W-1:0] : n[W-1:0];
            pend_den <= (mode == rau_pkg::MODE_TRUNC) ? (W-1)'(1) : d[W-2:0];
            pend_st <= rau_pkg::ST_OK;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          if (!ov || out_ch.ready) begin
            o_num <= pend_num;
            o_den <= pend_den;
            o_lt <= pend_lt;
            o_eq <= pend_eq;
            o_st <= pend_st;
            ov <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rational_arithmetic_unit.sv */
// back-end steps: error and unused-mode items go straight to the output register; compare forms
// two cross products; truncate divides by the denominator; add/sub/mul/div form two or three
// products on the multiplier, take binary gcd steps, then divide numerator and denominator by the gcd
// the back end takes a new item only after the last has reached the output register; the queue holds two more
// reset: synchronous active-high rst empties the queue and the output register
module rational_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  rau_in_if.sink     in_ch,
  rau_out_if.source  out_ch
);

  // classified item from the front end and queue handshake
  rau_pkg::rau_item_t wr_item, rd_item;
  logic               push, pop, full, not_empty;

  // front: sign and magnitude split, unused mode, zero denominator and divide by zero checks
  rau_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .item  (wr_item)
  );

  // queue: lets the front keep taking items while the back iterates
  rau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (wr_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .rd_item   (rd_item)
  );

  // back: cross products on one shared multiplier, gcd, division, output item register
  rau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (not_empty),
    .q_item  (rd_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
